// ----- sv/sensor_response_packet_receiver_assert.svh -----
// Assertion macros shared by the checker of the reply packet receiver.
`ifndef SENSOR_RESPONSE_PACKET_RECEIVER_ASSERT_SVH
`define SENSOR_RESPONSE_PACKET_RECEIVER_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define SRPR_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("srpr check failed");

// A stalled transfer keeps its valid in the next cycle.
`define SRPR_ASSERT_HOLD(lbl, vld, rdy) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ((vld) && !(rdy)) |=> (vld)) \
		else $error("srpr valid dropped under stall");

`endif

// ----- sv/srpr_pkg.sv -----
`timescale 1ns / 1ps
package srpr_pkg;

	localparam int PKT_LEN    = 12;
	localparam int PKT_CNT_W  = 4;
	localparam int SUM_LEN    = 10;

	localparam logic [7:0] SYNC_BYTE     = 8'h55;
	localparam logic [7:0] HDR_BYTE1     = 8'hAA;
	localparam logic [7:0] HDR_BYTE2     = 8'h01;
	localparam logic [7:0] HDR_BYTE3     = 8'h00;
	localparam logic [7:0] CMD_ACK       = 8'h30;
	localparam logic [7:0] CMD_NACK      = 8'h31;
	localparam logic [7:0] MAX_NACK_CODE = 8'h12;
	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_TICK = 2'd1,
		KIND_ARM  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NACK     = 3'd1,
		ST_FORMAT   = 3'd2,
		ST_CHECKSUM = 3'd3,
		ST_TIMEOUT  = 3'd4
	} status_t;

	typedef struct packed {
		logic        valid;
		status_t     status;
		logic [31:0] param_value;
		logic [15:0] response_word;
	} result_t;

endpackage

// ----- sv/srpr_if.sv -----
`timescale 1ns / 1ps
interface srpr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] rx_byte;

	modport source (output valid, output kind, output rx_byte, input ready);
	modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface srpr_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] param_value;
	logic [15:0] response_word;

	modport source (output valid, output status, output param_value, output response_word,
		input ready);
	modport sink (input valid, input status, input param_value, input response_word,
		output ready);
endinterface

interface srpr_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- sv/srpr_judge.sv -----
`timescale 1ns / 1ps
module srpr_judge
	import srpr_pkg::*;
(
	input  logic [7:0]  pkt [PKT_LEN],
	input  logic [15:0] sum,
	output result_t     res
);

	logic        fmt_bad;
	logic        sum_bad;
	logic        is_nack;
	logic [15:0] sent_sum;

	assign sent_sum = {pkt[PKT_LEN-1], pkt[PKT_LEN-2]};
	assign fmt_bad  = (pkt[0] != SYNC_BYTE) || (pkt[1] != HDR_BYTE1) ||
		(pkt[2] != HDR_BYTE2) || (pkt[3] != HDR_BYTE3) || (pkt[9] != 8'h00) ||
		((pkt[8] != CMD_ACK) && (pkt[8] != CMD_NACK));
	assign sum_bad  = (sent_sum != sum);
	assign is_nack  = (pkt[8] == CMD_NACK) && (pkt[4] != 8'h00);

	always_comb begin
		res.valid         = 1'b1;
		res.status        = ST_OK;
		res.param_value   = {pkt[7], pkt[6], pkt[5], pkt[4]};
		res.response_word = {pkt[9], pkt[8]};
		if (fmt_bad || (!sum_bad && is_nack && (pkt[4] > MAX_NACK_CODE))) begin
			res.status = ST_FORMAT;
		end else if (sum_bad) begin
			res.status = ST_CHECKSUM;
		end else if (is_nack) begin
			res.status = ST_NACK;
		end
		if (res.status != ST_OK && res.status != ST_NACK) begin
			res.param_value   = '0;
			res.response_word = '0;
		end
	end

endmodule

// ----- sv/srpr_collector.sv -----
`timescale 1ns / 1ps
module srpr_collector
	import srpr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  kind_t       kind,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_wr,
	input  logic [15:0] cfg_data,
	output result_t     res
);

	logic                 armed_q, armed_d;
	logic                 synced_q, synced_d;
	logic [PKT_CNT_W-1:0] count_q, count_d;
	logic [15:0]          elapsed_q, elapsed_d;
	logic [15:0]          sum_q, sum_d;
	logic [15:0]          timeout_q;
	logic [7:0]           store_q [PKT_LEN];

	logic                 wr_en;
	logic [PKT_CNT_W-1:0] idx;
	logic [PKT_CNT_W-1:0] base_cnt;
	logic [15:0]          base_sum;
	logic [15:0]          elapsed_inc;
	logic [7:0]           pkt [PKT_LEN];
	result_t              judge_res;

	// current byte stands in for the last entry; earlier entries come from the store
	always_comb begin
		for (int i = 0; i < PKT_LEN - 1; i++) begin
			pkt[i] = store_q[i];
		end
		pkt[PKT_LEN-1] = rx_byte;
	end

	srpr_judge u_judge (
		.pkt (pkt),
		.sum (sum_q),
		.res (judge_res)
	);

	assign base_cnt    = synced_q ? count_q : '0;
	assign base_sum    = synced_q ? sum_q : '0;
	assign idx         = (base_cnt >= PKT_CNT_W'(PKT_LEN)) ? '0 : base_cnt;
	assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;

	always_comb begin
		armed_d   = armed_q;
		synced_d  = synced_q;
		count_d   = count_q;
		elapsed_d = elapsed_q;
		sum_d     = sum_q;
		wr_en     = 1'b0;
		res       = '0;
		res.status = ST_OK;
		case (kind)
			KIND_ARM: begin
				armed_d   = 1'b1;
				synced_d  = 1'b0;
				count_d   = '0;
				elapsed_d = '0;
				sum_d     = '0;
			end
			KIND_TICK: begin
				if (armed_q) begin
					elapsed_d = elapsed_inc;
					if (elapsed_inc >= timeout_q) begin
						armed_d    = 1'b0;
						synced_d   = 1'b0;
						res.valid  = 1'b1;
						res.status = ST_TIMEOUT;
					end
				end
			end
			KIND_BYTE: begin
				if (armed_q && (synced_q || rx_byte == SYNC_BYTE)) begin
					synced_d = 1'b1;
					wr_en    = 1'b1;
					sum_d    = (idx < PKT_CNT_W'(SUM_LEN)) ? base_sum + {8'h00, rx_byte}
						: base_sum;
					count_d  = idx + 1'b1;
					if (idx == PKT_CNT_W'(PKT_LEN - 1)) begin
						armed_d  = 1'b0;
						synced_d = 1'b0;
						res      = judge_res;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q   <= 1'b0;
			synced_q  <= 1'b0;
			count_q   <= '0;
			elapsed_q <= '0;
			sum_q     <= '0;
		end else if (step) begin
			armed_q   <= armed_d;
			synced_q  <= synced_d;
			count_q   <= count_d;
			elapsed_q <= elapsed_d;
			sum_q     <= sum_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_wr) begin
			timeout_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < PKT_LEN; i++) begin
			if (step && wr_en && idx == PKT_CNT_W'(i)) begin
				store_q[i] <= rx_byte;
			end
		end
	end

endmodule

// ----- sv/sensor_response_packet_receiver.sv -----
`timescale 1ns / 1ps
// Reply packet receiver for a serial sensor link.
// pkt_in  : valid/ready channel of items; kind selects a received byte, a millisecond
//           tick or an arm command, rx_byte carries the byte.
// res_out : valid/ready channel of results: status, 32-bit parameter, response word.
// cfg     : valid/ready write channel for timeout_ms; always ready, takes effect on
//           the next item. Write it only while no item is in flight.
// An arm item opens a wait for one 12-byte packet. Bytes before the 0x55 sync byte
// are dropped; the twelfth byte of the packet or a timeout tick yields one result.
// Timing: one item per cycle while no result waits on res_out. An accepted item is held
// in the input register, is processed in a single pass through the collector and the
// packet checks, and its result is captured in the result register as the input
// register advances, which it does whenever the result register is free or draining.
// Stalls: while a result waits and res_out is not ready, the input register still
// takes one more item if it is empty; pkt_in.ready then drops until the waiting result is transferred.
// Reset: arst_n clears the channel valids, the armed/sync state and the counters,
// and loads timeout_ms with 1000. Packet bytes are not cleared.
module sensor_response_packet_receiver
	import srpr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	srpr_in_if.sink    pkt_in,
	srpr_out_if.source res_out,
	srpr_cfg_if.sink   cfg
);

	// input register
	logic       valid_s1;
	kind_t      kind_s1;
	logic [7:0] byte_s1;

	// result register
	logic        out_valid_q;
	status_t     status_q;
	logic [31:0] param_q;
	logic [15:0] resp_q;

	logic    advance;
	result_t res;

	// advance a held input item whenever the result register is free or draining
	assign advance      = valid_s1 && (!out_valid_q || res_out.ready);
	assign pkt_in.ready = !valid_s1 || advance;
	assign cfg.ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt_in.ready) begin
			valid_s1 <= pkt_in.valid;
		end
	end

	// payload needs no reset; capture only on a transfer
	always_ff @(posedge clk) begin
		if (pkt_in.ready && pkt_in.valid) begin
			kind_s1 <= kind_t'(pkt_in.kind);
			byte_s1 <= pkt_in.rx_byte;
		end
	end

	srpr_collector u_collector (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.kind     (kind_s1),
		.rx_byte  (byte_s1),
		.cfg_wr   (cfg.valid),
		.cfg_data (cfg.data),
		.res      (res)
	);

	// hold a result until transferred; drop valid once taken with nothing behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end else if (res_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			status_q <= res.status;
			param_q  <= res.param_value;
			resp_q   <= res.response_word;
		end
	end

	assign res_out.valid         = out_valid_q;
	assign res_out.status        = status_q;
	assign res_out.param_value   = param_q;
	assign res_out.response_word = resp_q;

endmodule

// ----- sv/srpr_checker.sv -----
`timescale 1ns / 1ps
`include "sensor_response_packet_receiver_assert.svh"
module srpr_checker
	import srpr_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [2:0]  status,
	input logic [31:0] param_value,
	input logic [15:0] response_word
);

	logic err_status;

	assign err_status = (status == ST_FORMAT) || (status == ST_CHECKSUM) ||
		(status == ST_TIMEOUT);

	`SRPR_ASSERT_HOLD(a_res_hold, res_valid, res_ready)
	`SRPR_ASSERT(a_err_zero, res_valid && err_status,
		param_value == 32'h0 && response_word == 16'h0)
	`SRPR_ASSERT(a_ok_cmd, res_valid && (status == ST_OK || status == ST_NACK),
		response_word == {8'h00, CMD_ACK} || response_word == {8'h00, CMD_NACK})
	`SRPR_ASSERT(a_nack_code, res_valid && status == ST_NACK,
		response_word == {8'h00, CMD_NACK} && param_value[7:0] != 8'h00 &&
		param_value[7:0] <= MAX_NACK_CODE)
	`SRPR_ASSERT(a_in_free, !res_valid, in_ready)

endmodule

bind sensor_response_packet_receiver srpr_checker u_srpr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (pkt_in.ready),
	.res_valid     (res_out.valid),
	.res_ready     (res_out.ready),
	.status        (res_out.status),
	.param_value   (res_out.param_value),
	.response_word (res_out.response_word)
);

// ----- bench/reply_packet_checker.sv -----
`timescale 1ns / 1ps
// Watches the item, result and register channels and predicts each reply from the item stream.
module reply_packet_checker
	import srpr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	srpr_in_if   pkt_in,
	srpr_out_if  res_out,
	srpr_cfg_if  cfg,
	output int   fail_count,
	output int   pending
);

	typedef struct packed {
		status_t     status;
		logic [31:0] param_value;
		logic [15:0] response_word;
	} reply_t;

	reply_t      expected_replies[$];
	int          errors;
	logic [15:0] timeout_limit;
	logic        armed;
	logic        synced;
	logic [3:0]  byte_count;
	logic [15:0] elapsed_ms;
	logic [15:0] byte_sum;
	logic [7:0]  packet_bytes [PKT_LEN];

	// Judge a complete packet: header, command word, checksum, then the NACK code.
	function automatic reply_t judge_packet();
		reply_t      r;
		logic [15:0] sent_sum;
		r.status = ST_FORMAT;
		r.param_value = '0;
		r.response_word = '0;
		sent_sum = {packet_bytes[11], packet_bytes[10]};
		if (packet_bytes[0] != SYNC_BYTE || packet_bytes[1] != HDR_BYTE1 ||
				packet_bytes[2] != HDR_BYTE2 || packet_bytes[3] != HDR_BYTE3 ||
				packet_bytes[9] != '0 ||
				(packet_bytes[8] != CMD_ACK && packet_bytes[8] != CMD_NACK))
			return r;
		if (sent_sum != byte_sum) begin
			r.status = ST_CHECKSUM;
			return r;
		end
		if (packet_bytes[8] == CMD_NACK && packet_bytes[4] != '0) begin
			if (packet_bytes[4] > MAX_NACK_CODE)
				return r;
			r.status = ST_NACK;
		end else begin
			r.status = ST_OK;
		end
		r.param_value = {packet_bytes[7], packet_bytes[6], packet_bytes[5], packet_bytes[4]};
		r.response_word = {packet_bytes[9], packet_bytes[8]};
		return r;
	endfunction

	// Advance the predicted state by one accepted item.
	task automatic take_item(input logic [1:0] kind, input logic [7:0] value);
		reply_t r;
		if (kind == KIND_ARM) begin
			armed = 1'b1;
			synced = 1'b0;
			byte_count = '0;
			elapsed_ms = '0;
			byte_sum = '0;
		end else if (armed && kind == KIND_TICK) begin
			if (elapsed_ms != 16'hFFFF)
				elapsed_ms = elapsed_ms + 16'd1;
			if (elapsed_ms >= timeout_limit) begin
				armed = 1'b0;
				synced = 1'b0;
				r.status = ST_TIMEOUT;
				r.param_value = '0;
				r.response_word = '0;
				expected_replies.push_back(r);
			end
		end else if (armed && kind == KIND_BYTE && (synced || value == SYNC_BYTE)) begin
			if (!synced) begin
				synced = 1'b1;
				byte_count = '0;
				byte_sum = '0;
			end
			if (byte_count >= PKT_LEN)
				byte_count = '0;
			packet_bytes[byte_count] = value;
			if (byte_count < SUM_LEN)
				byte_sum = byte_sum + 16'(value);
			byte_count = byte_count + 4'd1;
			if (byte_count == PKT_LEN) begin
				armed = 1'b0;
				synced = 1'b0;
				expected_replies.push_back(judge_packet());
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		reply_t want;
		if (!arst_n) begin
			expected_replies.delete();
			errors = 0;
			timeout_limit = TIMEOUT_RESET;
			armed = 1'b0;
			synced = 1'b0;
			byte_count = '0;
			elapsed_ms = '0;
			byte_sum = '0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (res_out.valid && res_out.ready) begin
				if (expected_replies.size() == 0) begin
					errors++;
					$display("%0t: reply with none expected: status %0d param %h word %h",
						$time, res_out.status, res_out.param_value, res_out.response_word);
				end else begin
					want = expected_replies.pop_front();
					if (res_out.status !== want.status) begin
						errors++;
						$display("%0t: status expected %0d got %0d",
							$time, want.status, res_out.status);
					end
					if (res_out.param_value !== want.param_value) begin
						errors++;
						$display("%0t: param_value expected %h got %h",
							$time, want.param_value, res_out.param_value);
					end
					if (res_out.response_word !== want.response_word) begin
						errors++;
						$display("%0t: response_word expected %h got %h",
							$time, want.response_word, res_out.response_word);
					end
				end
			end
			if (cfg.valid && cfg.ready)
				timeout_limit = cfg.data;
			if (pkt_in.valid && pkt_in.ready)
				take_item(pkt_in.kind, pkt_in.rx_byte);
			fail_count <= errors;
			pending <= expected_replies.size();
		end
	end

endmodule

// ----- bench/sensor_response_packet_receiver_test.sv -----
`timescale 1ns / 1ps
// Stimulus and verdict for the reply packet receiver; checking lives in reply_packet_checker.
module sensor_response_packet_receiver_test;
	import srpr_pkg::*;

	// the one kind value the block leaves unused
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 1_000_000;
	// covers the input and result registers between transfer and result, plus margin
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASE_ITEMS = 175;

	typedef enum int {
		FLAW_NONE,
		FLAW_HEADER,
		FLAW_UPPER_CMD,
		FLAW_SUM
	} flaw_t;

	logic        clk;
	logic        arst_n;
	int          fail_count;
	int          pending;
	int          cycle_count;
	int          useful_items;
	logic [15:0] timeout_setting;
	// when set, neither side inserts random gaps or stalls
	bit          calm;

	srpr_in_if  pkt_in ();
	srpr_out_if res_out ();
	srpr_cfg_if cfg ();

	sensor_response_packet_receiver uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pkt_in  (pkt_in),
		.res_out (res_out),
		.cfg     (cfg)
	);

	reply_packet_checker reply_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.pkt_in     (pkt_in),
		.res_out    (res_out),
		.cfg        (cfg),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Gap length for either side: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Present one item and hold it until its transfer. Valid stays high afterwards,
	// so the caller either presents the next item or drops valid in the same step.
	task automatic send_item(input logic [1:0] kind, input logic [7:0] value,
			input bit in_sequence);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			pkt_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pkt_in.valid <= 1'b1;
		pkt_in.kind <= kind;
		pkt_in.rx_byte <= value;
		@(posedge clk);
		while (!pkt_in.ready) @(posedge clk);
		if (in_sequence)
			useful_items++;
	endtask

	// Drop valid and hold off until every expected reply is back, then let the
	// pipeline empty of items that give no reply.
	task automatic drain();
		pkt_in.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [15:0] value);
		drain();
		cfg.valid <= 1'b1;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		timeout_setting = value;
	endtask

	// Build and send one reply packet from its sync byte on, with an optional flaw
	// and ticks sprinkled between bytes.
	task automatic send_reply(input logic [7:0] cmd, input logic [7:0] code,
			input flaw_t flaw, input int tick_pct);
		logic [7:0]  bytes [PKT_LEN];
		logic [15:0] sum;
		int          pos;
		bytes[0] = SYNC_BYTE;
		bytes[1] = HDR_BYTE1;
		bytes[2] = HDR_BYTE2;
		bytes[3] = HDR_BYTE3;
		bytes[4] = code;
		for (int i = 5; i < 8; i++)
			bytes[i] = ($urandom_range(0, 9) == 0) ? SYNC_BYTE : 8'($urandom);
		bytes[8] = cmd;
		bytes[9] = '0;
		// corrupt the header or the upper command byte before summing, so the
		// format check is what catches it
		if (flaw == FLAW_HEADER) begin
			pos = $urandom_range(1, 3);
			bytes[pos] = bytes[pos] ^ 8'($urandom_range(1, 255));
		end
		if (flaw == FLAW_UPPER_CMD)
			bytes[9] = 8'($urandom_range(1, 255));
		sum = '0;
		for (int i = 0; i < SUM_LEN; i++)
			sum = sum + 16'(bytes[i]);
		bytes[10] = sum[7:0];
		bytes[11] = sum[15:8];
		if (flaw == FLAW_SUM) begin
			pos = $urandom_range(10, 11);
			bytes[pos] = bytes[pos] ^ 8'($urandom_range(1, 255));
		end
		for (int i = 0; i < PKT_LEN; i++) begin
			if (i > 0 && $urandom_range(0, 99) < tick_pct)
				send_item(KIND_TICK, 8'($urandom), 1'b1);
			send_item(KIND_BYTE, bytes[i], 1'b1);
		end
	endtask

	// One random sequence: mostly full packets with random content, some flawed, the rest
	// cut-short packets, tick runs, noise and the odd full pause.
	task automatic run_sequence();
		int         pick;
		int         r;
		flaw_t      flaw;
		logic [7:0] cmd;
		logic [7:0] code;
		logic [7:0] junk;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			r = $urandom_range(0, 99);
			flaw = (r < 55) ? FLAW_NONE : (r < 70) ? FLAW_HEADER :
				(r < 82) ? FLAW_UPPER_CMD : FLAW_SUM;
			r = $urandom_range(0, 99);
			cmd = (r < 45) ? CMD_ACK : (r < 90) ? CMD_NACK : 8'($urandom);
			// spread the code over zero, the valid NACK codes and beyond them
			r = $urandom_range(0, 99);
			if (r < 30)
				code = '0;
			else if (r < 65)
				code = 8'($urandom_range(1, MAX_NACK_CODE));
			else if (r < 85)
				code = 8'($urandom_range(MAX_NACK_CODE + 1, 255));
			else
				code = 8'($urandom);
			send_item(KIND_ARM, 8'($urandom), 1'b1);
			// bytes ahead of the sync byte are dropped
			repeat ($urandom_range(0, 3)) begin
				junk = 8'($urandom);
				if (junk == SYNC_BYTE)
					junk = ~junk;
				send_item(KIND_BYTE, junk, 1'b1);
			end
			send_reply(cmd, code, flaw, 4);
		end else if (pick < 78) begin
			// cut a packet short; the next arm restarts the wait
			send_item(KIND_ARM, 8'($urandom), 1'b1);
			send_item(KIND_BYTE, SYNC_BYTE, 1'b1);
			repeat ($urandom_range(1, 10))
				send_item(KIND_BYTE, 8'($urandom), 1'b1);
		end else if (pick < 86) begin
			// run the clock out where the setting is short enough to reach
			send_item(KIND_ARM, 8'($urandom), 1'b1);
			r = (timeout_setting <= 48) ? int'(timeout_setting) + $urandom_range(0, 2) :
				$urandom_range(1, 20);
			repeat (r)
				send_item(KIND_TICK, 8'($urandom), 1'b1);
		end else if (pick < 96) begin
			repeat ($urandom_range(1, 6))
				send_item(2'($urandom), 8'($urandom), 1'b0);
		end else begin
			drain();
		end
	endtask

	// Result side: accept for a while, then stall for a random gap.
	initial begin : receiver
		int stall;
		res_out.ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			res_out.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				res_out.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Watchdog: end the run if it never reaches its verdict.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** sensor_response_packet_receiver: FAILED **");
		$finish;
	end

	initial begin : stimulus
		logic [15:0] setting;
		arst_n = 1'b0;
		pkt_in.valid = 1'b0;
		pkt_in.kind = KIND_BYTE;
		pkt_in.rx_byte = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		calm = 1'b0;
		useful_items = 0;
		timeout_setting = TIMEOUT_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: items while idle are ignored, including the unused kind
		send_item(KIND_TICK, 8'hFF, 1'b0);
		send_item(KIND_BYTE, SYNC_BYTE, 1'b0);
		send_item(KIND_UNUSED, 8'h00, 1'b0);
		// a clean ACK under the reset timeout, with a byte dropped ahead of sync
		send_item(KIND_ARM, 8'h00, 1'b0);
		send_item(KIND_BYTE, 8'hFF, 1'b0);
		send_reply(CMD_ACK, '0, FLAW_NONE, 0);
		// re-arm part-way through a packet; the wait starts afresh
		send_item(KIND_ARM, 8'h00, 1'b0);
		send_item(KIND_BYTE, SYNC_BYTE, 1'b0);
		send_item(KIND_BYTE, HDR_BYTE1, 1'b0);
		send_item(KIND_ARM, 8'hFF, 1'b0);
		// zero timeout: the first tick after arming times out, a later byte is ignored
		write_timeout(16'd0);
		send_item(KIND_ARM, 8'h00, 1'b0);
		send_item(KIND_TICK, 8'h00, 1'b0);
		send_item(KIND_BYTE, SYNC_BYTE, 1'b0);
		// timeout of one, hit while collecting
		write_timeout(16'd1);
		send_item(KIND_ARM, 8'h00, 1'b0);
		send_item(KIND_BYTE, SYNC_BYTE, 1'b0);
		send_item(KIND_TICK, 8'hFF, 1'b0);

		// Random phases, each under its own timeout setting; the third runs without random gaps
		useful_items = 0;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: setting = 16'hFFFF;
				1: setting = TIMEOUT_RESET;
				2: setting = 16'($urandom_range(20, 60));
				3: setting = 16'($urandom_range(2, 8));
				4: setting = 16'd1;
				default: setting = 16'($urandom_range(9, 30));
			endcase
			write_timeout(setting);
			calm = (phase == 2);
			while (useful_items < (phase + 1) * PHASE_ITEMS)
				run_sequence();
		end

		drain();
		if (fail_count == 0 && pending == 0)
			$display("** sensor_response_packet_receiver: PASSED **");
		else
			$display("** sensor_response_packet_receiver: FAILED **");
		$finish;
	end

endmodule
